// ----- hw/rtl/ned_pkg.sv -----
// ned_pkg: shared types and constants for the normalized euclidean distance unit
// no dependencies
package ned_pkg;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SQRT,
    ST_RDA,
    ST_DIVA,
    ST_DIVB,
    ST_ACC,
    ST_OUT
  } ned_state_e;

  localparam int unsigned SumW  = 42;
  localparam int unsigned AccW  = 40;
  localparam int unsigned DistW = 19;
  localparam int unsigned QW    = 17;
  localparam logic [DistW-1:0] DistMax = DistW'(262144);

endpackage

// ----- hw/rtl/normalized_euclidean_distance_unit.sv -----
// normalized_euclidean_distance_unit: top level, stores two vectors and gives the
// squared distance of their l2-normalized forms; uses ned_pkg
//
// Element pairs load at one beat per cycle into two synchronous memories
// while the sums of squares accumulate. On the last beat the unit stops
// taking beats, takes both norms with a bit-serial square root, then walks
// the stored pairs: per pair a memory read state and two restoring
// divisions, then a square-and-add state. The result waits in an output
// register; a stalled result holds off new beats. With a zero norm the
// result follows the square root directly.
module normalized_euclidean_distance_unit #(
  parameter int unsigned MAX_DIM    = 1024,
  parameter int unsigned ELEM_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  output logic                    stall_o,
  input  logic signed [ELEM_WIDTH-1:0] a_element_i,
  input  logic signed [ELEM_WIDTH-1:0] b_element_i,
  input  logic                    last_element_i,
  output logic                    valid_o,
  input  logic                    stall_i,
  output logic [ned_pkg::DistW-1:0] distance_o,
  output logic                    zero_norm_o,
  output logic                    too_long_o
);
  import ned_pkg::*;

  localparam int unsigned AW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CW = $clog2(MAX_DIM + 1);
  localparam int unsigned MW = ELEM_WIDTH;       // magnitude width
  localparam int unsigned RW = SumW / 2;         // root width
  localparam int unsigned NW = MW + 16;          // dividend width
  localparam int unsigned DC = NW;               // division steps

  logic signed [ELEM_WIDTH-1:0] mem_a [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] mem_b [MAX_DIM];
  logic signed [ELEM_WIDTH-1:0] rd_a_q, rd_b_q;

  ned_state_e state_q, state_d;
  logic [SumW-1:0] suma_q, sumb_q;
  logic [CW-1:0]   cnt_q;
  logic            ovf_q;
  logic [AccW-1:0] acc_q;
  logic [AW-1:0]   idx_q;
  logic [AW-1:0]   rd_idx;
  // sqrt state, both vectors in parallel
  logic [SumW-1:0] rema_q, remb_q;
  logic [RW-1:0]   roota_q, rootb_q;
  logic [4:0]      sstep_q;
  // divider
  logic [NW-1:0]   dvd_q;
  logic [RW:0]     drem_q;
  logic [5:0]      dstep_q;
  logic [QW-1:0]   qa_q;
  logic            nega_q, negb_q;
  logic [QW-1:0]   qb_q;
  logic            ov_q;
  logic [DistW-1:0] dist_q;
  logic            zn_q, tl_q;

  logic acc_in, out_take;
  assign out_take = valid_o && !stall_i;
  assign stall_o  = (state_q != ST_LOAD) || (valid_o && stall_i);
  assign acc_in   = valid_i && !stall_o;
  assign valid_o  = ov_q;
  assign distance_o  = dist_q;
  assign zero_norm_o = zn_q;
  assign too_long_o  = tl_q;

  logic [MW-1:0] mag_a, mag_b;
  assign mag_a = a_element_i[ELEM_WIDTH-1] ? MW'(-a_element_i) : MW'(a_element_i);
  assign mag_b = b_element_i[ELEM_WIDTH-1] ? MW'(-b_element_i) : MW'(b_element_i);

  function automatic logic [SumW-1:0] sat_add(input logic [SumW-1:0] s,
                                              input logic [2*MW-1:0] v);
    logic [SumW:0] t;
    t = {1'b0, s} + (SumW+1)'(v);
    return t[SumW] ? '1 : t[SumW-1:0];
  endfunction

  logic in_room;
  assign in_room = cnt_q < CW'(MAX_DIM);

  // read one ahead so the pair is ready when the walk reaches it
  assign rd_idx = (state_q == ST_ACC)  ? idx_q + AW'(1) :
                  (state_q == ST_SQRT) ? '0 : idx_q;

  // memories
  always_ff @(posedge clk_i) begin
    if (acc_in && in_room) begin
      mem_a[cnt_q[AW-1:0]] <= a_element_i;
      mem_b[cnt_q[AW-1:0]] <= b_element_i;
    end
    rd_a_q <= mem_a[rd_idx];
    rd_b_q <= mem_b[rd_idx];
  end

  // one sqrt step on (rem, root) with bit position taken from sstep
  function automatic logic [SumW+RW-1:0] sq_step(input logic [SumW-1:0] rem,
                                                 input logic [RW-1:0] root,
                                                 input logic [4:0] k);
    logic [SumW:0] trial;
    logic [SumW-1:0] bitv;
    bitv  = SumW'(1) << (2 * k);
    trial = {1'b0, rem} - ((SumW+1)'(root) << (k + 1)) - (SumW+1)'(bitv);
    if (!trial[SumW]) return {trial[SumW-1:0], root | (RW'(1) << k)};
    return {rem, root};
  endfunction

  logic [RW-1:0] nsel;
  assign nsel = (state_q == ST_DIVA) ? roota_q : rootb_q;

  logic [RW:0] dtrial_src;
  logic [RW+1:0] dtrial;
  assign dtrial_src = {drem_q[RW-1:0], dvd_q[NW-1]};
  assign dtrial = {1'b0, dtrial_src} - (RW+2)'(nsel);

  logic [NW-1:0] qfull;
  assign qfull = {dvd_q[NW-2:0], !dtrial[RW+1]};
  logic [QW-1:0] qclamp;
  assign qclamp = (qfull > NW'(65536)) ? QW'(65536) : QW'(qfull);

  logic signed [QW+1:0] diff;
  assign diff = (nega_q ? -$signed({2'b0, qa_q}) : $signed({2'b0, qa_q})) -
                (negb_q ? -$signed({2'b0, qb_q}) : $signed({2'b0, qb_q}));
  logic [QW:0] dmag;
  assign dmag = diff[QW+1] ? (QW+1)'(0) - diff[QW:0] : diff[QW:0];
  logic [2*QW+1:0] dsq;
  assign dsq = dmag * dmag;
  logic [AccW:0] acc_sum;
  assign acc_sum = {1'b0, acc_q} + (AccW+1)'(dsq);

  logic [SumW+RW-1:0] sa, sb;
  assign sa = sq_step(rema_q, roota_q, sstep_q);
  assign sb = sq_step(remb_q, rootb_q, sstep_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: if (acc_in && last_element_i) state_d = ST_SQRT;
      ST_SQRT: if (sstep_q == 5'd0) begin
        state_d = (sa[RW-1:0] == '0 || sb[RW-1:0] == '0) ? ST_LOAD : ST_RDA;
      end
      ST_RDA:  state_d = ST_DIVA;
      ST_DIVA: if (dstep_q == 6'd0) state_d = ST_DIVB;
      ST_DIVB: if (dstep_q == 6'd0) state_d = ST_ACC;
      ST_ACC:  state_d = (CW'(idx_q) + CW'(1) >= cnt_q) ? ST_OUT : ST_RDA;
      ST_OUT:  state_d = ST_LOAD;
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      suma_q <= '0; sumb_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
      acc_q <= '0; idx_q <= '0; sstep_q <= '0; dstep_q <= '0;
      ov_q <= 1'b0; roota_q <= '0; rootb_q <= '0;
      rema_q <= '0; remb_q <= '0; dvd_q <= '0; drem_q <= '0;
      qa_q <= '0; qb_q <= '0; nega_q <= 1'b0; negb_q <= 1'b0;
      dist_q <= '0; zn_q <= 1'b0; tl_q <= 1'b0;
    end else begin
      if (out_take) ov_q <= 1'b0;
      case (state_q)
        ST_LOAD: if (acc_in) begin
          if (in_room) begin
            suma_q <= sat_add(suma_q, mag_a * mag_a);
            sumb_q <= sat_add(sumb_q, mag_b * mag_b);
            cnt_q  <= cnt_q + CW'(1);
          end else begin
            ovf_q <= 1'b1;
          end
          if (last_element_i) begin
            rema_q <= in_room ? sat_add(suma_q, mag_a * mag_a) : suma_q;
            remb_q <= in_room ? sat_add(sumb_q, mag_b * mag_b) : sumb_q;
            roota_q <= '0; rootb_q <= '0;
            sstep_q <= 5'(RW - 1);
          end
        end
        ST_SQRT: begin
          rema_q <= sa[SumW+RW-1:RW]; roota_q <= sa[RW-1:0];
          remb_q <= sb[SumW+RW-1:RW]; rootb_q <= sb[RW-1:0];
          sstep_q <= sstep_q - 5'd1;
          if (sstep_q == 5'd0) begin
            idx_q <= '0;
            acc_q <= '0;
            if (sa[RW-1:0] == '0 || sb[RW-1:0] == '0) begin
              zn_q <= 1'b1; dist_q <= '0; tl_q <= ovf_q; ov_q <= 1'b1;
              suma_q <= '0; sumb_q <= '0; cnt_q <= '0; ovf_q <= 1'b0;
            end
          end
        end
        ST_RDA: begin
          dvd_q <= {MW'(rd_a_q[ELEM_WIDTH-1] ? -rd_a_q : rd_a_q), 16'(0)} +
                   NW'(roota_q >> 1);
          nega_q <= rd_a_q[ELEM_WIDTH-1];
          drem_q <= '0; dstep_q <= 6'(DC - 1);
        end
        ST_DIVA, ST_DIVB: begin
          if (dstep_q != 6'd0) begin
            dvd_q  <= qfull;
            drem_q <= dtrial[RW+1] ? dtrial_src : dtrial[RW:0];
            dstep_q <= dstep_q - 6'd1;
          end else if (state_q == ST_DIVA) begin
            qa_q <= qclamp;
            dvd_q <= {MW'(rd_b_q[ELEM_WIDTH-1] ? -rd_b_q : rd_b_q), 16'(0)} +
                     NW'(rootb_q >> 1);
            negb_q <= rd_b_q[ELEM_WIDTH-1];
            drem_q <= '0; dstep_q <= 6'(DC - 1);
          end else begin
            qb_q <= qclamp;
          end
        end
        ST_ACC: begin
          acc_q <= acc_sum[AccW] ? '1 : acc_sum[AccW-1:0];
          idx_q <= idx_q + AW'(1);
        end
        ST_OUT: begin
          dist_q <= (((AccW+1)'(acc_q) + (AccW+1)'(32768)) >> 16) > (AccW+1)'(DistMax)
                    ? DistMax : DistW'(((AccW+1)'(acc_q) + (AccW+1)'(32768)) >> 16);
          zn_q <= 1'b0; tl_q <= ovf_q; ov_q <= 1'b1;
          suma_q <= '0; sumb_q <= '0; cnt_q <= '0; ovf_q <= 1'b0; acc_q <= '0;
        end
        default: ;
      endcase
      state_q <= state_d;
    end
  end

endmodule
